// File: rtl/core/stp_pkg.sv
package stp_pkg;

  localparam int STEPS_PER_REV_DEF = 4096;
  localparam int US_PER_MIN        = 60000000;

  localparam logic [8:0]  DEG_MAX     = 9'd360;
  localparam logic [13:0] PERIOD_MAX  = 14'd16383;
  localparam logic [7:0]  SEQ_DIVISOR = 8'd45;
  localparam logic [18:0] SEQ_RECIP   = 19'd372828;
  localparam int          SEQ_SHIFT   = 18;
  localparam logic [7:0]  SPEED_RESET = 8'd10;
  localparam int          SEQ_W       = 10;
  localparam int          STEPS_W     = 13;
  localparam int          TICK_W      = 14;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PER_RUN,
    ST_DONE
  } state_t;

  function automatic logic [3:0] half_pattern(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0: pat = 4'd1;
      3'd1: pat = 4'd3;
      3'd2: pat = 4'd2;
      3'd3: pat = 4'd6;
      3'd4: pat = 4'd4;
      3'd5: pat = 4'd12;
      3'd6: pat = 4'd8;
      3'd7: pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

// File: rtl/core/stp_div.sv
module stp_div #(
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [7:0]    divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CntW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_r, dvd_nxt;
  logic [7:0]      rem_r, rem_nxt;
  logic [7:0]      dsr_r;
  logic [CntW-1:0] cnt_r;
  logic            done_r;
  logic [8:0]      trial;
  logic            ge;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, dvd_r[DW-1]};
    ge      = (trial >= {1'b0, dsr_r});
    rem_nxt = ge ? 8'(trial - {1'b0, dsr_r}) : trial[7:0];
    dvd_nxt = {dvd_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CntW'(DW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CntW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// File: rtl/core/stepper_half_step_positioner.sv
// a tick word or a refused or null move command gives its result in the cycle after accept
// a real move command waits in ST_PER_RUN for the one-bit-per-cycle divider to work out the
// step period, then commits in ST_DONE once the result register is free
// throughput: one word at a time, the next is taken once idle and the result register is free
// reset: synchronous active low; position 0, coils off, idle, speed 10 rpm
module stepper_half_step_positioner #(
  parameter int STEPS_PER_REV = stp_pkg::STEPS_PER_REV_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_speed_rpm,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [8:0] in_target_angle,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_coil_pattern,
  output logic       out_pattern_changed,
  output logic       out_busy_res,
  output logic       out_rejected,
  output logic [8:0] out_position
);

  localparam int BASE_TICKS = stp_pkg::US_PER_MIN / STEPS_PER_REV;
  localparam int BASE_W     = $clog2(BASE_TICKS + 1);
  localparam int DIV_W      = (BASE_W > 15) ? BASE_W : 15;
  localparam int PROD_W     = stp_pkg::SEQ_SHIFT + stp_pkg::SEQ_W;

  stp_pkg::state_t state_r, state_nxt;

  logic [7:0]                   speed_r;
  logic [8:0]                   pos_r, pos_nxt;
  logic [stp_pkg::STEPS_W-1:0]  steps_r, steps_nxt;
  logic [2:0]                   phase_r, phase_nxt;
  logic                         ccw_r, ccw_nxt;
  logic [stp_pkg::TICK_W-1:0]   tick_r, tick_nxt;
  logic [stp_pkg::TICK_W-1:0]   period_r, period_nxt;
  logic [3:0]                   coils_r, coils_nxt;
  logic                         moving_r, moving_nxt;
  logic [8:0]                   tgt_r;
  logic                         ccw_pend_r;
  logic [stp_pkg::SEQ_W-1:0]    seqs_r;

  logic       out_valid_r;
  logic [3:0] out_coil_r;
  logic       out_changed_r, out_busy_r, out_rej_r;
  logic [8:0] out_pos_r;

  logic                       acc, is_move, bad, start_move, out_free;
  logic                       div_start, load_res, commit;
  logic [DIV_W-1:0]           div_dvd, div_quo;
  logic [7:0]                 div_dsr, rpm_eff;
  logic                       div_done;
  logic [8:0]                 mag;
  logic [PROD_W-1:0]          seq_prod;
  logic [stp_pkg::TICK_W-1:0] tick_inc, period_sat;
  logic                       changed_nxt, rejected_nxt;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign is_move   = (in_func == stp_pkg::FUNC_MOVE);
  assign bad       = (in_target_angle > stp_pkg::DEG_MAX) || moving_r;
  assign start_move = acc && is_move && !bad && (in_target_angle != pos_r);
  assign mag       = (in_target_angle > pos_r) ? 9'(in_target_angle - pos_r)
                                               : 9'(pos_r - in_target_angle);
  assign rpm_eff   = (speed_r == 8'd0) ? 8'd1 : speed_r;

  // floor(mag * 64 / 45) by reciprocal multiply
  assign seq_prod  = PROD_W'(mag) * PROD_W'(stp_pkg::SEQ_RECIP);

  assign div_dvd   = DIV_W'(BASE_TICKS);
  assign div_dsr   = rpm_eff;

  stp_div #(
    .DW(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stp_pkg::ST_IDLE:    if (start_move) state_nxt = stp_pkg::ST_PER_RUN;
      stp_pkg::ST_PER_RUN: if (div_done) state_nxt = stp_pkg::ST_DONE;
      stp_pkg::ST_DONE:    if (out_free) state_nxt = stp_pkg::ST_IDLE;
      default:             state_nxt = stp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_res  = 1'b0;
    commit    = 1'b0;
    case (state_r)
      stp_pkg::ST_IDLE: begin
        in_ready  = out_free;
        div_start = start_move;
        load_res  = acc && !start_move;
      end
      stp_pkg::ST_PER_RUN: begin
      end
      stp_pkg::ST_DONE: begin
        commit   = out_free;
        load_res = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (div_quo > DIV_W'(stp_pkg::PERIOD_MAX)) begin
      period_sat = stp_pkg::PERIOD_MAX;
    end else if (div_quo == '0) begin
      period_sat = stp_pkg::TICK_W'(1);
    end else begin
      period_sat = div_quo[stp_pkg::TICK_W-1:0];
    end
  end

  assign tick_inc = tick_r + 1'b1;

  // state update
  always_comb begin
    pos_nxt      = pos_r;
    steps_nxt    = steps_r;
    phase_nxt    = phase_r;
    ccw_nxt      = ccw_r;
    tick_nxt     = tick_r;
    period_nxt   = period_r;
    coils_nxt    = coils_r;
    moving_nxt   = moving_r;
    changed_nxt  = 1'b0;
    rejected_nxt = acc && is_move && bad;
    if (acc && !is_move && moving_r) begin
      tick_nxt = tick_inc;
      if (tick_inc >= period_r) begin
        tick_nxt = '0;
        if (steps_r != '0) begin
          phase_nxt   = ccw_r ? 3'(phase_r + 3'd1) : 3'(phase_r - 3'd1);
          coils_nxt   = stp_pkg::half_pattern(phase_nxt);
          steps_nxt   = steps_r - 1'b1;
          changed_nxt = 1'b1;
        end else begin
          moving_nxt = 1'b0;
        end
      end
    end
    if (commit) begin
      pos_nxt     = tgt_r;
      ccw_nxt     = ccw_pend_r;
      phase_nxt   = ccw_pend_r ? 3'd0 : 3'd7;
      steps_nxt   = {seqs_r, 3'b000} - 1'b1;
      period_nxt  = period_sat;
      tick_nxt    = '0;
      moving_nxt  = 1'b1;
      coils_nxt   = stp_pkg::half_pattern(phase_nxt);
      changed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stp_pkg::ST_IDLE;
      speed_r     <= stp_pkg::SPEED_RESET;
      pos_r       <= '0;
      steps_r     <= '0;
      phase_r     <= '0;
      ccw_r       <= 1'b0;
      tick_r      <= '0;
      period_r    <= '0;
      coils_r     <= '0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      steps_r  <= steps_nxt;
      phase_r  <= phase_nxt;
      ccw_r    <= ccw_nxt;
      tick_r   <= tick_nxt;
      period_r <= period_nxt;
      coils_r  <= coils_nxt;
      moving_r <= moving_nxt;
      if (cfg_valid && cfg_ready) begin
        speed_r <= cfg_speed_rpm;
      end
      if (load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_move) begin
      tgt_r      <= in_target_angle;
      ccw_pend_r <= (in_target_angle < pos_r);
      seqs_r     <= seq_prod[stp_pkg::SEQ_SHIFT +: stp_pkg::SEQ_W];
    end
    if (load_res) begin
      out_coil_r    <= coils_nxt;
      out_changed_r <= changed_nxt;
      out_busy_r    <= moving_nxt;
      out_rej_r     <= rejected_nxt;
      out_pos_r     <= pos_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_coil_pattern    = out_coil_r;
  assign out_pattern_changed = out_changed_r;
  assign out_busy_res        = out_busy_r;
  assign out_rejected        = out_rej_r;
  assign out_position        = out_pos_r;

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (period_r != '0))
    else $error("moving with zero step period");

  a_steps_need_move: assert property (@(posedge clk) disable iff (!rst_n)
    (steps_r != '0) |-> moving_r)
    else $error("steps left while not moving");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= stp_pkg::DEG_MAX)
    else $error("stored position above range");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != stp_pkg::ST_IDLE) |-> !in_ready)
    else $error("ready while a move is being set up");

  a_per_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stp_pkg::ST_PER_RUN && div_done) |=> (state_r == stp_pkg::ST_DONE))
    else $error("move not committed after period divide");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [3:0] coil;
    logic       changed;
    logic       busy;
    logic       rejected;
    logic [8:0] pos;
  } drive_result_t;

  localparam logic [3:0] HALF_SEQ [8] = '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_speed_rpm = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_func = 1'b0;
  logic [8:0] in_target_angle = 9'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_coil_pattern;
  logic       out_pattern_changed;
  logic       out_busy_res;
  logic       out_rejected;
  logic [8:0] out_position;

  // motor state as the block should hold it
  logic [7:0]  speed_set = stp_pkg::SPEED_RESET;
  logic [8:0]  pos_deg = 9'd0;
  logic [12:0] steps_todo = 13'd0;
  logic [2:0]  phase_idx = 3'd0;
  logic        dir_ccw = 1'b0;
  logic [13:0] tick_cnt = 14'd0;
  logic [13:0] hold_period = 14'd0;
  logic [3:0]  coils = 4'd0;
  logic        run_flag = 1'b0;

  logic [9:0]    word_q[$];
  logic [9:0]    next_word;
  drive_result_t expected_drive_q[$];
  drive_result_t want;
  int unsigned   words_popped = 0;
  int unsigned   results_owed = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   errors = 0;
  bit            in_took = 1'b0;
  bit            no_idle = 1'b0;

  stepper_half_step_positioner dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_speed_rpm      (cfg_speed_rpm),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_target_angle    (in_target_angle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_coil_pattern   (out_coil_pattern),
    .out_pattern_changed(out_pattern_changed),
    .out_busy_res       (out_busy_res),
    .out_rejected       (out_rejected),
    .out_position       (out_position)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [13:0] step_delay(input logic [7:0] rpm);
    int base;
    int p;
    base = stp_pkg::US_PER_MIN / stp_pkg::STEPS_PER_REV_DEF;
    p = base / ((rpm == 8'd0) ? 1 : int'(rpm));
    if (p > int'(stp_pkg::PERIOD_MAX)) p = int'(stp_pkg::PERIOD_MAX);
    if (p == 0) p = 1;
    return 14'(p);
  endfunction

  function automatic drive_result_t advance_motor(input logic func, input logic [8:0] ang);
    drive_result_t r;
    int span;
    int sets;
    r = '0;
    if (func == stp_pkg::FUNC_MOVE) begin
      if (ang > stp_pkg::DEG_MAX || run_flag) begin
        r.rejected = 1'b1;
      end else if (ang != pos_deg) begin
        if (ang > pos_deg) begin
          span = int'(ang) - int'(pos_deg);
          dir_ccw = 1'b0;
          phase_idx = 3'd7;
        end else begin
          span = int'(pos_deg) - int'(ang);
          dir_ccw = 1'b1;
          phase_idx = 3'd0;
        end
        sets = (span * 64) / int'(stp_pkg::SEQ_DIVISOR);
        steps_todo = 13'(sets * 8 - 1);
        hold_period = step_delay(speed_set);
        tick_cnt = 14'd0;
        run_flag = 1'b1;
        coils = HALF_SEQ[phase_idx];
        r.changed = 1'b1;
        pos_deg = ang;
      end
    end else if (run_flag) begin
      tick_cnt = tick_cnt + 14'd1;
      if (tick_cnt >= hold_period) begin
        tick_cnt = 14'd0;
        if (steps_todo != 13'd0) begin
          phase_idx = dir_ccw ? phase_idx + 3'd1 : phase_idx - 3'd1;
          coils = HALF_SEQ[phase_idx];
          steps_todo = steps_todo - 13'd1;
          r.changed = 1'b1;
        end else begin
          run_flag = 1'b0;
        end
      end
    end
    r.coil = coils;
    r.busy = run_flag;
    r.pos = pos_deg;
    return r;
  endfunction

  always @(posedge clk) in_took = rst_n && in_valid && in_ready;

  always @(negedge clk) begin
    if (!rst_n || !in_valid || in_took) begin
      if (rst_n && word_q.size() != 0 && (no_idle || $urandom_range(99) >= 20)) begin
        next_word = word_q.pop_front();
        in_valid <= 1'b1;
        in_func <= next_word[9];
        in_target_angle <= next_word[8:0];
        expected_drive_q.push_back(advance_motor(next_word[9], next_word[8:0]));
        results_owed++;
        words_popped++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_cycles != 0) begin
      out_ready <= 1'b0;
      stall_cycles--;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_drive_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = expected_drive_q.pop_front();
        results_owed--;
        if (out_coil_pattern !== want.coil) begin
          $error("coil_pattern: expected %0d, got %0d", want.coil, out_coil_pattern);
          errors++;
        end
        if (out_pattern_changed !== want.changed) begin
          $error("pattern_changed: expected %0d, got %0d", want.changed, out_pattern_changed);
          errors++;
        end
        if (out_busy_res !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, out_busy_res);
          errors++;
        end
        if (out_rejected !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, out_rejected);
          errors++;
        end
        if (out_position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, out_position);
          errors++;
        end
      end
    end
  end

  task automatic send_word(input logic func, input logic [8:0] ang);
    int unsigned seen;
    seen = words_popped;
    word_q.push_back({func, ang});
    wait (words_popped != seen);
  endtask

  task automatic set_speed(input logic [7:0] rpm);
    wait (results_owed == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_speed_rpm <= rpm;
    do @(posedge clk); while (!cfg_ready);
    speed_set = rpm;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // tick until the move and its final delay are over, with a random move word now and then if poke is set
  task automatic run_to_rest(input bit poke);
    while (run_flag) begin
      if (poke && $urandom_range(63) == 0) send_word(stp_pkg::FUNC_MOVE, 9'($urandom));
      else send_word(stp_pkg::FUNC_TICK, 9'($urandom));
    end
  endtask

  task automatic run_ticks(input int unsigned n, input bit poke);
    repeat (n) begin
      if (poke && $urandom_range(15) == 0) send_word(stp_pkg::FUNC_MOVE, 9'($urandom));
      else send_word(stp_pkg::FUNC_TICK, 9'($urandom));
    end
  endtask

  task automatic test_reset_state();
    send_word(stp_pkg::FUNC_TICK, 9'd0);
    send_word(stp_pkg::FUNC_TICK, 9'd511);
    send_word(stp_pkg::FUNC_MOVE, 9'd361);
    send_word(stp_pkg::FUNC_MOVE, 9'd511);
    send_word(stp_pkg::FUNC_MOVE, 9'd0);
  endtask

  task automatic test_cw_turn();
    set_speed(8'd255);
    send_word(stp_pkg::FUNC_MOVE, 9'd1);
    send_word(stp_pkg::FUNC_MOVE, 9'd0);
    send_word(stp_pkg::FUNC_MOVE, 9'd361);
    run_to_rest(1'b1);
  endtask

  task automatic test_output_stall();
    send_word(stp_pkg::FUNC_MOVE, 9'd0);
    @(posedge clk);
    stall_cycles = 300;
    run_ticks(200, 1'b0);
    wait (results_owed == 0);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    run_ticks(150, 1'b1);
    send_word(stp_pkg::FUNC_MOVE, 9'd360);
    no_idle = 1'b0;
  endtask

  task automatic test_speed_latched();
    set_speed(8'd0);
    send_word(stp_pkg::FUNC_MOVE, 9'd5);
    run_ticks(40, 1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_cw_turn();
    test_output_stall();
    test_back_to_back();
    test_speed_latched();
    wait (results_owed == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
rtl/core/stp_pkg.sv
rtl/core/stp_div.sv
rtl/core/stepper_half_step_positioner.sv
test/testbench.sv
